// ===== hw/rtl/upd_pkg.sv =====
// Shared types, character constants and hex helper for the URL percent decoder.
package upd_pkg;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    localparam int STAT_W  = 16;
    localparam int QDEPTH  = 8;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);
    localparam int MAX_RES = 3;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              out_last;
        logic [STAT_W-1:0] bad_escapes;
        logic              was_changed;
        logic [STAT_W-1:0] decoded_length;
    } t_result;

    typedef struct packed {
        logic [1:0]          count;
        t_result [MAX_RES-1:0] ent;
    } t_push;

    // {valid, nibble}
    function automatic logic [4:0] hex_decode(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, c[3:0]};
        end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            r = {1'b1, c[3:0] + 4'd9};
        end
        return r;
    endfunction

endpackage

// ===== hw/rtl/upd_core.sv =====
// Decode step: held-escape state, per-string tallies, up to three results per beat.
module upd_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_acc,
    input  logic [7:0]    i_in_byte,
    input  logic          i_in_last,
    output upd_pkg::t_push o_push
);

    logic [1:0]             r_held_count, n_held_count;
    logic [7:0]             r_held_hex, n_held_hex;
    logic [COUNT_WIDTH-1:0] r_bad, n_bad;
    logic [COUNT_WIDTH-1:0] r_len, n_len;
    logic                   r_chg, n_chg;

    logic [4:0] hb, hh;
    logic       pl_hold, pl_chg;
    logic [7:0] pl_byte;
    logic [7:0] e_byte [upd_pkg::MAX_RES];
    logic [1:0] k, nb, hc;
    logic       chg;
    logic [COUNT_WIDTH:0] bad_sum, len_sum;
    logic [63:0] bad_wide, len_wide;

    assign hb = upd_pkg::hex_decode(i_in_byte);
    assign hh = upd_pkg::hex_decode(r_held_hex);
    assign pl_hold = (i_in_byte == upd_pkg::CH_PERCENT);
    assign pl_chg  = (i_in_byte == upd_pkg::CH_PLUS);
    assign pl_byte = pl_chg ? upd_pkg::CH_SPACE : i_in_byte;

    always_comb begin
        k = 2'd0;
        nb = 2'd0;
        hc = 2'd0;
        chg = r_chg;
        n_held_hex = r_held_hex;
        for (int i = 0; i < upd_pkg::MAX_RES; i++) begin
            e_byte[i] = 8'd0;
        end
        unique case (r_held_count)
            2'd0: begin
                if (pl_hold) begin
                    hc = 2'd1;
                end else begin
                    e_byte[k] = pl_byte;
                    k = k + 2'd1;
                    chg = chg | pl_chg;
                end
            end
            2'd1: begin
                if (hb[4]) begin
                    hc = 2'd2;
                    n_held_hex = i_in_byte;
                end else begin
                    e_byte[k] = upd_pkg::CH_PERCENT;
                    k = k + 2'd1;
                    nb = nb + 2'd1;
                    if (pl_hold) begin
                        hc = 2'd1;
                    end else begin
                        e_byte[k] = pl_byte;
                        k = k + 2'd1;
                        chg = chg | pl_chg;
                    end
                end
            end
            default: begin
                if (hb[4]) begin
                    e_byte[k] = {hh[3:0], hb[3:0]};
                    k = k + 2'd1;
                    chg = 1'b1;
                end else begin
                    e_byte[k] = upd_pkg::CH_PERCENT;
                    k = k + 2'd1;
                    nb = nb + 2'd1;
                    e_byte[k] = r_held_hex;
                    k = k + 2'd1;
                    if (pl_hold) begin
                        hc = 2'd1;
                    end else begin
                        e_byte[k] = pl_byte;
                        k = k + 2'd1;
                        chg = chg | pl_chg;
                    end
                end
            end
        endcase
        if (i_in_last && hc != 2'd0) begin
            e_byte[k] = upd_pkg::CH_PERCENT;
            k = k + 2'd1;
            nb = nb + 2'd1;
            if (hc == 2'd2) begin
                e_byte[k] = n_held_hex;
                k = k + 2'd1;
            end
        end
    end

    // Saturating tallies: adding at most 3 never wraps past the carry bit.
    assign bad_sum = {1'b0, r_bad} + (COUNT_WIDTH+1)'(nb);
    assign len_sum = {1'b0, r_len} + (COUNT_WIDTH+1)'(k);
    assign bad_wide = 64'(n_bad);
    assign len_wide = 64'(n_len);

    always_comb begin
        n_bad = bad_sum[COUNT_WIDTH] ? '1 : bad_sum[COUNT_WIDTH-1:0];
        n_len = len_sum[COUNT_WIDTH] ? '1 : len_sum[COUNT_WIDTH-1:0];
        n_chg = chg;
        n_held_count = hc;
    end

    always_comb begin
        o_push.count = i_acc ? k : 2'd0;
        for (int i = 0; i < upd_pkg::MAX_RES; i++) begin
            o_push.ent[i].out_byte       = e_byte[i];
            o_push.ent[i].out_last       = 1'b0;
            o_push.ent[i].bad_escapes    = '0;
            o_push.ent[i].was_changed    = 1'b0;
            o_push.ent[i].decoded_length = '0;
            if (i_in_last && (32'(i) + 1 == 32'(k))) begin
                o_push.ent[i].out_last = 1'b1;
                o_push.ent[i].bad_escapes = (bad_wide > 64'hFFFF) ? 16'hFFFF
                                                                  : bad_wide[15:0];
                o_push.ent[i].was_changed = n_chg;
                o_push.ent[i].decoded_length = (len_wide > 64'hFFFF) ? 16'hFFFF
                                                                     : len_wide[15:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_count <= 2'd0;
            r_held_hex   <= 8'd0;
            r_bad        <= '0;
            r_len        <= '0;
            r_chg        <= 1'b0;
        end else if (i_acc) begin
            if (i_in_last) begin
                r_held_count <= 2'd0;
                r_held_hex   <= 8'd0;
                r_bad        <= '0;
                r_len        <= '0;
                r_chg        <= 1'b0;
            end else begin
                r_held_count <= n_held_count;
                r_held_hex   <= n_held_hex;
                r_bad        <= n_bad;
                r_len        <= n_len;
                r_chg        <= n_chg;
            end
        end
    end

endmodule

// ===== hw/rtl/upd_fifo.sv =====
// Result queue: takes up to three results per cycle, delivers one beat per cycle while i_pop is high.
module upd_fifo (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  upd_pkg::t_push             i_push,
    input  logic                       i_pop,
    output upd_pkg::t_result           o_head,
    output logic                       o_valid,
    output logic [upd_pkg::QCNT_W-1:0] o_level
);

    upd_pkg::t_result r_mem [upd_pkg::QDEPTH];
    logic [upd_pkg::QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [upd_pkg::QCNT_W-1:0] r_count, n_count;
    logic                       pop;

    assign pop     = i_pop && (r_count != '0);
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd_ptr];
    assign o_level = r_count;
    assign n_count = r_count + upd_pkg::QCNT_W'(i_push.count)
                   - upd_pkg::QCNT_W'(pop);

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < upd_pkg::MAX_RES; i++) begin
            if (32'(i) < 32'(i_push.count)) begin
                r_mem[r_wr_ptr + upd_pkg::QPTR_W'(i)] <= i_push.ent[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + upd_pkg::QPTR_W'(i_push.count);
            r_rd_ptr <= r_rd_ptr + upd_pkg::QPTR_W'(pop);
            r_count  <= n_count;
        end
    end

endmodule

// ===== hw/rtl/url_percent_decoder.sv =====
// Top level of the lenient URL percent decoder.
//
//  channel  dir  handshake                    content
//  s_axis   in   s_axis_tvalid/s_axis_tready  tdata: in_byte; tlast: in_last
//  m_axis   out  m_axis_tvalid/m_axis_tready  tdata: out_byte, bad_escapes,
//                                             was_changed, decoded_length; tlast
//
// One input beat per cycle while s_axis_tready is high; each beat is decoded in the
// cycle it is taken and yields zero to three result beats, written into an 8-entry result queue.
// Results leave in order, one per cycle while m_axis_tready is high.
// s_axis_tready drops while the queue has fewer than three free entries.
// Synchronous active-low reset clears held bytes, tallies and the queue.
module url_percent_decoder #(
    parameter int COUNT_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [7:0] out_byte, [23:8] bad_escapes,
                                        // [24] was_changed, [40:25] decoded_length
    output logic        m_axis_tlast
);

    upd_pkg::t_push             push;
    upd_pkg::t_result           head;
    logic [upd_pkg::QCNT_W-1:0] level;
    logic                       acc;

    assign s_axis_tready = (level <= upd_pkg::QCNT_W'(upd_pkg::QDEPTH - upd_pkg::MAX_RES));
    assign acc = s_axis_tvalid && s_axis_tready;

    upd_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_in_byte (s_axis_tdata),
        .i_in_last (s_axis_tlast),
        .o_push    (push)
    );

    upd_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_head  (head),
        .o_valid (m_axis_tvalid),
        .o_level (level)
    );

    assign m_axis_tdata = {7'd0, head.decoded_length, head.was_changed,
                           head.bad_escapes, head.out_byte};
    assign m_axis_tlast = head.out_last;

    a_level_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        level <= upd_pkg::QCNT_W'(upd_pkg::QDEPTH))
        else $error("result queue overfilled");

    a_last_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && s_axis_tlast |-> push.count != 2'd0)
        else $error("string end produced no result");

    a_last_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc && s_axis_tlast |=> m_axis_tvalid)
        else $error("no result pending after string end");

    a_push_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !acc |-> push.count == 2'd0)
        else $error("results written without input beat");

endmodule

// ===== test/tb_url_percent_decoder.sv =====
// Self-checking bench for url_percent_decoder: predicts the decoded beats and checks the output.
`timescale 1ns / 1ps

module tb_url_percent_decoder;

    localparam int CYCLE_LIMIT = 1_000_000;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_raw_beat;

    typedef struct packed {
        logic [7:0]                 data;
        logic                       last;
        logic [upd_pkg::STAT_W-1:0] bad;
        logic                       changed;
        logic [upd_pkg::STAT_W-1:0] len;
    } t_dec_beat;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = 8'h00;   // [7:0] in_byte
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;            // [7:0] out_byte, [23:8] bad_escapes,
                                          // [24] was_changed, [40:25] decoded_length
    logic        m_axis_tlast;

    url_percent_decoder u_dut (.*);

    // decoder state as predicted
    logic [1:0]                 esc_depth    = 2'd0;
    logic [7:0]                 esc_digit    = 8'h00;
    logic [upd_pkg::STAT_W-1:0] bad_tally    = '0;
    logic [upd_pkg::STAT_W-1:0] len_tally    = '0;
    logic                       changed_seen = 1'b0;

    t_dec_beat step_beats[$];
    t_dec_beat want_decoded[$];
    t_raw_beat raw_beats[$];
    t_raw_beat on_bus;

    bit in_taken     = 1'b0;
    bit quiet        = 1'b0;
    int send_gap     = 0;
    int stall_left   = 0;
    int hold_request = 0;
    int err_count    = 0;
    int cycles       = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic is_hex(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
               (c >= 8'h61 && c <= 8'h66);
    endfunction

    function automatic logic [3:0] nibble(input logic [7:0] c);
        logic [7:0] v;
        if (c <= 8'h39) begin
            v = c - 8'h30;
        end else if (c <= 8'h46) begin
            v = c - 8'h37;
        end else begin
            v = c - 8'h57;
        end
        return v[3:0];
    endfunction

    // mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task report(input string what, input logic [upd_pkg::STAT_W-1:0] got,
                input logic [upd_pkg::STAT_W-1:0] want);
        $display("%0t mismatch on %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
        err_count++;
    endtask

    task push_out(input logic [7:0] b);
        step_beats.push_back('{data: b, last: 1'b0, bad: '0, changed: 1'b0, len: '0});
        if (len_tally != '1) len_tally++;
    endtask

    task push_bad_pct();
        if (bad_tally != '1) bad_tally++;
        push_out(upd_pkg::CH_PERCENT);
    endtask

    task take_plain(input logic [7:0] b);
        if (b == upd_pkg::CH_PERCENT) begin
            esc_depth = 2'd1;
        end else if (b == upd_pkg::CH_PLUS) begin
            changed_seen = 1'b1;
            push_out(upd_pkg::CH_SPACE);
        end else begin
            push_out(b);
        end
    endtask

    task predict_decode(input t_raw_beat rb);
        t_dec_beat tail;
        step_beats.delete();
        case (esc_depth)
            2'd0: begin
                take_plain(rb.data);
            end
            2'd1: begin
                if (is_hex(rb.data)) begin
                    esc_digit = rb.data;
                    esc_depth = 2'd2;
                end else begin
                    esc_depth = 2'd0;
                    push_bad_pct();
                    take_plain(rb.data);
                end
            end
            default: begin
                esc_depth = 2'd0;
                if (is_hex(rb.data)) begin
                    changed_seen = 1'b1;
                    push_out({nibble(esc_digit), nibble(rb.data)});
                end else begin
                    push_bad_pct();
                    push_out(esc_digit);
                    take_plain(rb.data);
                end
            end
        endcase
        if (rb.last) begin
            // escape cut off by the end of the string goes out raw
            if (esc_depth >= 2'd1) push_bad_pct();
            if (esc_depth >= 2'd2) push_out(esc_digit);
            if (step_beats.size() > 0) begin
                tail         = step_beats.pop_back();
                tail.last    = 1'b1;
                tail.bad     = bad_tally;
                tail.changed = changed_seen;
                tail.len     = len_tally;
                step_beats.push_back(tail);
            end
            esc_depth    = 2'd0;
            esc_digit    = 8'h00;
            bad_tally    = '0;
            len_tally    = '0;
            changed_seen = 1'b0;
        end
        foreach (step_beats[i]) want_decoded.push_back(step_beats[i]);
    endtask

    always @(posedge i_clk) begin : mon
        t_dec_beat want;
        in_taken = i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (want_decoded.size() == 0) begin
                report("unexpected beat, out_byte", m_axis_tdata[7:0], '0);
            end else begin
                want = want_decoded.pop_front();
                if (m_axis_tdata[7:0] != want.data)
                    report("out_byte", m_axis_tdata[7:0], want.data);
                if (m_axis_tlast != want.last)
                    report("out_last", m_axis_tlast, want.last);
                if (m_axis_tdata[23:8] != want.bad)
                    report("bad_escapes", m_axis_tdata[23:8], want.bad);
                if (m_axis_tdata[24] != want.changed)
                    report("was_changed", m_axis_tdata[24], want.changed);
                if (m_axis_tdata[40:25] != want.len)
                    report("decoded_length", m_axis_tdata[40:25], want.len);
            end
        end
        if (in_taken) predict_decode(on_bus);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    always @(negedge i_clk) begin : drv
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                s_axis_tvalid <= 1'b0;
            end else if (raw_beats.size() > 0) begin
                on_bus = raw_beats.pop_front();
                s_axis_tdata  <= on_bus.data;
                s_axis_tlast  <= on_bus.last;
                s_axis_tvalid <= 1'b1;
                send_gap = pick_gap();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : rcv
        if (hold_request > 0) begin
            stall_left   = hold_request;
            hold_request = 0;
        end
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    task add_beat(input logic [7:0] b, input logic last);
        raw_beats.push_back('{data: b, last: last});
    endtask

    task add_text(input string t);
        for (int i = 0; i < t.len(); i++) add_beat(t[i], i == t.len() - 1);
    endtask

    function automatic logic [7:0] rand_hex();
        int r;
        r = $urandom_range(0, 21);
        if (r < 10) return 8'(8'h30 + r);
        if (r < 16) return 8'(8'h61 + r - 10);
        return 8'(8'h41 + r - 16);
    endfunction

    // one string built from tokens: plain bytes, good and broken escapes, plus signs
    task automatic add_random_string(inout int budget);
        logic [7:0] str[$];
        logic [7:0] nh;
        int target;
        int kind;
        target = $urandom_range(1, 12);
        while (str.size() < target) begin
            kind = $urandom_range(0, 99);
            if (kind < 35) begin
                str.push_back(8'($urandom_range(0, 255)));
            end else if (kind < 60) begin
                str.push_back(upd_pkg::CH_PERCENT);
                str.push_back(rand_hex());
                str.push_back(rand_hex());
            end else if (kind < 70) begin
                str.push_back(upd_pkg::CH_PLUS);
            end else if (kind < 85) begin
                str.push_back(upd_pkg::CH_PERCENT);
                if ($urandom_range(0, 1)) str.push_back(rand_hex());
                do nh = 8'($urandom_range(0, 255)); while (is_hex(nh));
                str.push_back(nh);
            end else begin
                str.push_back(upd_pkg::CH_PERCENT);
            end
        end
        foreach (str[i]) add_beat(str[i], i == str.size() - 1);
        budget -= str.size();
    endtask

    task wait_idle();
        while (raw_beats.size() != 0 || s_axis_tvalid || want_decoded.size() != 0)
            @(posedge i_clk);
    endtask

    initial begin : stim
        int budget;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        add_beat(8'h00, 1'b1);
        add_beat(8'hFF, 1'b1);
        add_text("%7e+%Fa");
        add_text("%g1");
        add_text("%4");
        add_text("%");
        add_text("%%41");
        add_text("%4%");
        add_text("+");
        wait_idle();

        // long output stall while the input keeps offering beats
        hold_request = 250;
        budget = 30;
        while (budget > 0) add_random_string(budget);
        wait_idle();

        budget = 45;
        while (budget > 0) add_random_string(budget);
        wait_idle();

        quiet = 1'b1;
        budget = 25;
        while (budget > 0) add_random_string(budget);
        wait_idle();
        quiet = 1'b0;

        repeat (20) @(posedge i_clk);
        if (err_count == 0 && want_decoded.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
